/* hw/rtl/sh_order2_rotate_assert.svh */
// Assertion macros for the rotation block.
`ifndef SH_ORDER2_ROTATE_ASSERT_SVH
`define SH_ORDER2_ROTATE_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define SH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sh_order2_rotate: check failed");

// Invariant checked at every rising edge outside reset.
`define SH_ASSERT_ALW(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sh_order2_rotate: check failed");

`endif

/* hw/rtl/shr2_pkg.sv */
`timescale 1ns / 1ps
package shr2_pkg;
    localparam int COEF_WIDTH_DEF   = 32;
    localparam int MATRIX_WIDTH_DEF = 16;
    localparam int CONST_FRAC       = 16;
    localparam int KW               = 18;
    localparam logic signed [KW-1:0] K_ROOT3      = 18'sd113512;
    localparam logic signed [KW-1:0] K_HALF_ROOT3 = 18'sd56756;
    localparam logic signed [KW-1:0] K_HALF       = 18'sd32768;
    localparam int PIPE_DEPTH       = 8;
    localparam int APB_AW           = 5;
    localparam int APB_DW           = 64;

    typedef enum logic [1:0] {
        REG_ROW_ZERO = 2'd0,
        REG_ROW_ONE  = 2'd1,
        REG_ROW_TWO  = 2'd2
    } t_reg_idx;
endpackage

/* hw/rtl/shr2_band2.sv */
`timescale 1ns / 1ps
module shr2_band2 #(
    parameter int CW = 32,
    parameter int MW = 16
) (
    input  logic                 i_clk,
    input  logic signed [MW-1:0] i_m [3][3],
    input  logic signed [CW-1:0] i_s [5],
    output logic signed [CW-1:0] o_out [5]
);
    import shr2_pkg::*;

    localparam int MF   = MW - 2;
    localparam int CVW  = MW + 1;
    localparam int P6W  = CW + KW;
    localparam int SHW  = CW + 4;
    localparam int QRW  = 2 * MW + 3;
    localparam int QW   = MW + 6;
    localparam int PW   = SHW + QW;
    localparam int DW   = PW + 3;
    localparam int RW   = DW + 2 - MF;
    localparam int TW   = CW + 3;
    localparam int MPW  = TW + KW;
    localparam int SATW = (RW > MPW) ? RW : MPW;

    localparam logic signed [QRW-1:0] OFF1 =
        QRW'(((64'd1 << (2 * MF)) + 64'd1) / 64'd3);
    localparam logic signed [QRW-1:0] OFF2 =
        QRW'(((64'd1 << (2 * MF + 1)) + 64'd1) / 64'd3);
    localparam logic signed [P6W:0]   H6   = (P6W+1)'(1) <<< (CONST_FRAC - 1);
    localparam logic signed [QRW:0]   HQ   = (QRW+1)'(1) <<< (MF - 1);
    localparam logic signed [DW+1:0]  HD   = (DW+2)'(1) <<< (MF - 1);
    localparam logic signed [TW-1:0]  TLIM = TW'(1) <<< (CW + 1);
    localparam logic signed [MPW:0]   HM   = (MPW+1)'(1) <<< (CONST_FRAC - 1);

    function automatic logic signed [CW-1:0] sat_c(input logic signed [SATW-1:0] v);
        logic signed [CW-1:0] res;
        if ((&v[SATW-1:CW-1]) || !(|v[SATW-1:CW-1])) begin
            res = v[CW-1:0];
        end else if (v[SATW-1]) begin
            res = {1'b1, {(CW-1){1'b0}}};
        end else begin
            res = {1'b0, {(CW-1){1'b1}}};
        end
        return res;
    endfunction

    logic signed [CVW-1:0] r_v [3][5];
    logic signed [P6W-1:0] r_p6;
    logic signed [CW-1:0]  r_s1 [5];
    logic signed [SHW-1:0] r_sh2 [5];
    logic signed [SHW-1:0] r_sh3 [5];
    logic signed [SHW-1:0] n_sh [5];
    logic signed [QRW-1:0] r_qr [5][5];
    logic signed [QRW-1:0] n_qr [5][5];
    logic signed [QW-1:0]  r_q [5][5];
    logic signed [PW-1:0]  r_p [5][5];
    logic signed [DW-1:0]  r_d [5];
    logic signed [CW-1:0]  r_o6 [3];
    logic signed [CW-1:0]  r_o7 [3];
    logic signed [TW-1:0]  r_t [2];
    logic signed [MPW-1:0] r_mp [2];
    logic signed [CW-1:0]  r_out [5];

    // stage 1: column vectors and the root-three product
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_v[i][0] <= CVW'(i_m[i][0]);
            r_v[i][1] <= CVW'(i_m[i][2]);
            r_v[i][2] <= CVW'(i_m[i][0]) + CVW'(i_m[i][1]);
            r_v[i][3] <= CVW'(i_m[i][0]) + CVW'(i_m[i][2]);
            r_v[i][4] <= CVW'(i_m[i][1]) + CVW'(i_m[i][2]);
        end
        r_p6 <= P6W'(i_s[2]) * P6W'(K_ROOT3);
        r_s1 <= i_s;
    end

    // stage 2: projected sums and raw quadratic terms
    always_comb begin
        logic signed [P6W:0] r6;
        logic signed [QRW-1:0] x, y, z;
        r6 = ((P6W+1)'(r_p6) + H6) >>> CONST_FRAC;
        n_sh[0] = SHW'(r_s1[3]) + SHW'(r_s1[4]) + SHW'(r_s1[4]) - SHW'(r_s1[1]);
        n_sh[1] = SHW'(r_s1[0]) + SHW'(r6) + SHW'(r_s1[3]) + SHW'(r_s1[4]);
        n_sh[2] = SHW'(r_s1[0]);
        n_sh[3] = -SHW'(r_s1[3]);
        n_sh[4] = -SHW'(r_s1[1]);
        for (int k = 0; k < 5; k++) begin
            x = QRW'(r_v[0][k]);
            y = QRW'(r_v[1][k]);
            z = QRW'(r_v[2][k]);
            n_qr[k][0] = x * y;
            n_qr[k][1] = y * z;
            n_qr[k][2] = z * z - ((k < 2) ? OFF1 : OFF2);
            n_qr[k][3] = x * z;
            n_qr[k][4] = x * x - y * y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh2 <= n_sh;
        r_qr  <= n_qr;
    end

    // stages 3 to 5: round, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_sh3 <= r_sh2;
        for (int k = 0; k < 5; k++) begin
            for (int j = 0; j < 5; j++) begin
                r_q[k][j] <= QW'(((QRW+1)'(r_qr[k][j]) + HQ) >>> MF);
                r_p[k][j] <= PW'(r_sh3[k]) * PW'(r_q[k][j]);
            end
        end
        for (int j = 0; j < 5; j++) begin
            r_d[j] <= DW'(r_p[0][j]) + DW'(r_p[1][j]) + DW'(r_p[2][j])
                    + DW'(r_p[3][j]) + DW'(r_p[4][j]);
        end
    end

    // stage 6: round to coefficient format, clamp the scaled columns
    always_ff @(posedge i_clk) begin
        logic signed [DW+1:0] e [5];
        logic signed [RW-1:0] t;
        for (int j = 0; j < 5; j++) begin
            e[j] = ((j == 1) || (j == 3)) ? -(DW+2)'(r_d[j]) : (DW+2)'(r_d[j]);
            e[j] = (e[j] + HD) >>> MF;
        end
        r_o6[0] <= sat_c(SATW'(RW'(e[0])));
        r_o6[1] <= sat_c(SATW'(RW'(e[1])));
        r_o6[2] <= sat_c(SATW'(RW'(e[3])));
        for (int j = 0; j < 2; j++) begin
            t = RW'(e[2 + 2 * j]);
            if (t > RW'(TLIM)) begin
                r_t[j] <= TLIM;
            end else if (t < -RW'(TLIM)) begin
                r_t[j] <= -TLIM;
            end else begin
                r_t[j] <= TW'(t);
            end
        end
    end

    // stages 7 and 8: output scaling
    always_ff @(posedge i_clk) begin
        r_o7     <= r_o6;
        r_mp[0]  <= MPW'(r_t[0]) * MPW'(K_HALF_ROOT3);
        r_mp[1]  <= MPW'(r_t[1]) * MPW'(K_HALF);
        r_out[0] <= r_o7[0];
        r_out[1] <= r_o7[1];
        r_out[3] <= r_o7[2];
        r_out[2] <= sat_c(SATW'(((MPW+1)'(r_mp[0]) + HM) >>> CONST_FRAC));
        r_out[4] <= sat_c(SATW'(((MPW+1)'(r_mp[1]) + HM) >>> CONST_FRAC));
    end

    assign o_out = r_out;
endmodule

/* hw/rtl/sh_order2_rotate.sv */
`timescale 1ns / 1ps
// Rotation of a band 0..2 spherical-harmonic coefficient vector.
// Request channel: drive the nine coefficients and raise start; a request is
// taken at every rising edge with start high and busy low. busy is always low,
// so a new request may enter every cycle.
// Result channel: o_valid is high for exactly one cycle with the nine rotated
// coefficients; results come in request order.
// Throughput: one vector per cycle through the eight-stage datapath
// (column terms, quadratic terms, rounding, products, sums, rounding,
// output scaling, saturation), each stage with one multiplier row at most.
// The receiver cannot stall: results are shown once and not held.
// Matrix: three 48-bit rows on the APB port at byte addresses 0, 8 and 16,
// column c in bits 16c+15..16c, Q1.14. Write only while no request is in flight.
// Reset (synchronous, active low) clears the pipeline valid bits and loads
// the identity matrix; requests may follow in the next cycle.
module sh_order2_rotate #(
    parameter int COEF_WIDTH   = shr2_pkg::COEF_WIDTH_DEF,
    parameter int MATRIX_WIDTH = shr2_pkg::MATRIX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [shr2_pkg::APB_AW-1:0]  paddr,
    input  logic [shr2_pkg::APB_DW-1:0]  pwdata,
    output logic [shr2_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    input  logic signed [COEF_WIDTH-1:0] i_coef_in_zero,
    input  logic signed [COEF_WIDTH-1:0] i_coef_in_one,
    input  logic signed [COEF_WIDTH-1:0] i_coef_in_two,
    input  logic signed [COEF_WIDTH-1:0] i_coef_in_three,
    input  logic signed [COEF_WIDTH-1:0] i_coef_in_four,
    input  logic signed [COEF_WIDTH-1:0] i_coef_in_five,
    input  logic signed [COEF_WIDTH-1:0] i_coef_in_six,
    input  logic signed [COEF_WIDTH-1:0] i_coef_in_seven,
    input  logic signed [COEF_WIDTH-1:0] i_coef_in_eight,
    output logic                         o_valid,
    output logic signed [COEF_WIDTH-1:0] o_coef_out_zero,
    output logic signed [COEF_WIDTH-1:0] o_coef_out_one,
    output logic signed [COEF_WIDTH-1:0] o_coef_out_two,
    output logic signed [COEF_WIDTH-1:0] o_coef_out_three,
    output logic signed [COEF_WIDTH-1:0] o_coef_out_four,
    output logic signed [COEF_WIDTH-1:0] o_coef_out_five,
    output logic signed [COEF_WIDTH-1:0] o_coef_out_six,
    output logic signed [COEF_WIDTH-1:0] o_coef_out_seven,
    output logic signed [COEF_WIDTH-1:0] o_coef_out_eight
);
    import shr2_pkg::*;

    localparam int CW   = COEF_WIDTH;
    localparam int MW   = MATRIX_WIDTH;
    localparam int MF   = MW - 2;
    localparam int RGW  = 3 * MW;
    localparam int B1PW = CW + MW;
    localparam int B1W  = CW + MW + 3;
    localparam logic signed [B1W-1:0] HB = B1W'(1) <<< (MF - 1);

    function automatic logic signed [CW-1:0] sat_c(input logic signed [B1W-1:0] v);
        logic signed [CW-1:0] res;
        if ((&v[B1W-1:CW-1]) || !(|v[B1W-1:CW-1])) begin
            res = v[CW-1:0];
        end else if (v[B1W-1]) begin
            res = {1'b1, {(CW-1){1'b0}}};
        end else begin
            res = {1'b0, {(CW-1){1'b1}}};
        end
        return res;
    endfunction

    logic [RGW-1:0]         r_row [3];
    logic signed [MW-1:0]   w_m [3][3];
    logic                   r_vld [PIPE_DEPTH];
    logic signed [CW-1:0]   r_s0 [PIPE_DEPTH];
    logic signed [B1PW-1:0] r_b1p [3][3];
    logic signed [CW-1:0]   r_b1d [PIPE_DEPTH-1][3];
    logic signed [CW-1:0]   w_s2 [5];
    logic signed [CW-1:0]   w_b2 [5];
    logic                   w_req;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_req  = start && !busy;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= RGW'(1) << MF;
            r_row[1] <= RGW'(1) << (MF + MW);
            r_row[2] <= RGW'(1) << (MF + 2 * MW);
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg_idx'(paddr[4:3]))
                REG_ROW_ZERO: r_row[0] <= RGW'(pwdata);
                REG_ROW_ONE:  r_row[1] <= RGW'(pwdata);
                REG_ROW_TWO:  r_row[2] <= RGW'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:3]))
            REG_ROW_ZERO: prdata = APB_DW'(r_row[0]);
            REG_ROW_ONE:  prdata = APB_DW'(r_row[1]);
            REG_ROW_TWO:  prdata = APB_DW'(r_row[2]);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_m[r][c] = r_row[r][c*MW +: MW];
            end
        end
    end

    // valid bits and band 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= w_req;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0[0] <= i_coef_in_zero;
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            r_s0[i] <= r_s0[i-1];
        end
    end

    // band 1: products, then signed sum, round and saturate; hold to align
    always_ff @(posedge i_clk) begin
        logic signed [B1W-1:0] acc;
        for (int o = 0; o < 3; o++) begin
            r_b1p[o][0] <= B1PW'(w_m[(o + 1) % 3][1]) * B1PW'(i_coef_in_one);
            r_b1p[o][1] <= B1PW'(w_m[(o + 1) % 3][2]) * B1PW'(i_coef_in_two);
            r_b1p[o][2] <= B1PW'(w_m[(o + 1) % 3][0]) * B1PW'(i_coef_in_three);
            acc = B1W'(r_b1p[o][0]) - B1W'(r_b1p[o][1]) + B1W'(r_b1p[o][2]);
            if (o == 1) begin
                acc = -acc;
            end
            r_b1d[0][o] <= sat_c((acc + HB) >>> MF);
        end
        for (int i = 1; i < PIPE_DEPTH - 1; i++) begin
            r_b1d[i] <= r_b1d[i-1];
        end
    end

    assign w_s2[0] = i_coef_in_four;
    assign w_s2[1] = i_coef_in_five;
    assign w_s2[2] = i_coef_in_six;
    assign w_s2[3] = i_coef_in_seven;
    assign w_s2[4] = i_coef_in_eight;

    shr2_band2 #(
        .CW (CW),
        .MW (MW)
    ) u_band2 (
        .i_clk (i_clk),
        .i_m   (w_m),
        .i_s   (w_s2),
        .o_out (w_b2)
    );

    assign o_valid          = r_vld[PIPE_DEPTH-1];
    assign o_coef_out_zero  = r_s0[PIPE_DEPTH-1];
    assign o_coef_out_one   = r_b1d[PIPE_DEPTH-2][0];
    assign o_coef_out_two   = r_b1d[PIPE_DEPTH-2][1];
    assign o_coef_out_three = r_b1d[PIPE_DEPTH-2][2];
    assign o_coef_out_four  = w_b2[0];
    assign o_coef_out_five  = w_b2[1];
    assign o_coef_out_six   = w_b2[2];
    assign o_coef_out_seven = w_b2[3];
    assign o_coef_out_eight = w_b2[4];
endmodule

/* hw/rtl/shr2_check.sv */
`timescale 1ns / 1ps
`include "sh_order2_rotate_assert.svh"
module shr2_check #(
    parameter int CW = 32
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 pready,
    input logic                 o_valid,
    input logic signed [CW-1:0] i_coef_in_zero,
    input logic signed [CW-1:0] o_coef_out_zero
);
    import shr2_pkg::*;

    `SH_ASSERT_ALW(a_never_busy, i_clk, i_rst_n, !busy)
    `SH_ASSERT_ALW(a_ready, i_clk, i_rst_n, pready)
    `SH_ASSERT_IMP(a_valid_from_req, i_clk, i_rst_n, o_valid, $past(start, PIPE_DEPTH))
    `SH_ASSERT_IMP(a_band0_pass, i_clk, i_rst_n, o_valid, o_coef_out_zero == $past(i_coef_in_zero, PIPE_DEPTH))
endmodule

bind sh_order2_rotate shr2_check #(.CW(COEF_WIDTH)) u_shr2_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .pready          (pready),
    .o_valid         (o_valid),
    .i_coef_in_zero  (i_coef_in_zero),
    .o_coef_out_zero (o_coef_out_zero)
);
